FILE: sv/rgbbp_pkg.sv
package rgbbp_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_GREY_SHIFT  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 4'd3;

	// reset values of the registers before clamping
	localparam int GREY_SHIFT_RST  = 2;
	localparam int PLANE_COUNT_RST = 4;
	localparam int ROW_BYTES_RST   = 40;
	localparam int ROW_COUNT_RST   = 240;

	// largest values the register fields can carry
	localparam int ROW_BYTES_FIELD_MAX = 255;
	localparam int ROW_COUNT_FIELD_MAX = 2047;

	// luma weights in q16
	localparam int GREY_SUM_W = 22;
	localparam logic [GREY_SUM_W-1:0] W_RED   = 22'd19661;
	localparam logic [GREY_SUM_W-1:0] W_GREEN = 22'd38011;
	localparam logic [GREY_SUM_W-1:0] W_BLUE  = 22'd7209;

	localparam int ADDR_W = 20;

	// clamped configuration as seen by front and back
	typedef struct packed {
		logic [2:0]  grey_shift;
		logic [3:0]  plane_count;
		logic [7:0]  row_bytes;
		logic [10:0] row_count;
	} cfg_t;

	// one finished group of eight pixels on its way to the back end
	typedef struct packed {
		logic [7:0][7:0]    values;
		logic [ADDR_W-1:0]  start_addr;
		logic               frame_done;
	} desc_t;

endpackage

FILE: sv/rgbbp_front.sv
module rgbbp_front #(
	parameter int MAX_ROW_BYTES = 128,
	parameter int MAX_ROWS      = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rgbbp_pkg::cfg_t     cfg,
	input  logic                push,
	output logic                full,
	input  logic [15:0]         pixel_rgb565,
	input  logic                frame_start,
	output logic                q_wr,
	output rgbbp_pkg::desc_t    q_wr_data,
	input  logic                q_full
);
	import rgbbp_pkg::*;

	localparam int EFF_RB   = (MAX_ROW_BYTES > ROW_BYTES_FIELD_MAX) ?
		ROW_BYTES_FIELD_MAX : MAX_ROW_BYTES;
	localparam int EFF_ROWS = (MAX_ROWS > ROW_COUNT_FIELD_MAX) ?
		ROW_COUNT_FIELD_MAX : MAX_ROWS;
	localparam int CW = $clog2(EFF_RB * 8);
	localparam int RW = (EFF_ROWS > 1) ? $clog2(EFF_ROWS) : 1;

	logic                  valid_s1;
	logic [15:0]           pix_s1;
	logic                  fs_s1;

	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	logic [ADDR_W-1:0]     base_q;
	logic [7:0]            grp_q [8];

	logic [4:0]            red;
	logic [5:0]            green;
	logic [4:0]            blue;
	logic [GREY_SUM_W-1:0] grey_sum;
	logic [7:0]            grey;

	logic [CW-1:0]         col_cur;
	logic [RW-1:0]         row_cur;
	logic [ADDR_W-1:0]     base_cur;
	logic [CW:0]           col_inc;
	logic [RW:0]           row_inc;
	logic [11:0]           col_limit;
	logic                  last_col;
	logic                  last_row;
	logic                  group_done;
	logic                  stall;
	logic                  fire;
	logic                  accept;
	logic [ADDR_W-1:0]     row_stride;

	// grey value from the staged pixel
	always_comb begin
		red      = pix_s1[15:11];
		green    = pix_s1[10:5];
		blue     = pix_s1[4:0];
		grey_sum = GREY_SUM_W'(red) * W_RED + GREY_SUM_W'(green) * W_GREEN
			+ GREY_SUM_W'(blue) * W_BLUE;
		grey     = {2'b00, grey_sum[GREY_SUM_W-1:16]} >> cfg.grey_shift;
	end

	// position of this pixel, with frame start applied first
	always_comb begin
		col_cur    = fs_s1 ? '0 : col_q;
		row_cur    = fs_s1 ? '0 : row_q;
		base_cur   = fs_s1 ? '0 : base_q;
		col_inc    = {1'b0, col_cur} + (CW+1)'(1);
		row_inc    = {1'b0, row_cur} + (RW+1)'(1);
		col_limit  = {1'b0, cfg.row_bytes, 3'b000};
		last_col   = 12'(col_inc) >= col_limit;
		last_row   = 12'(row_inc) >= {1'b0, cfg.row_count};
		row_stride = ADDR_W'(12'(cfg.row_bytes) * 12'(cfg.plane_count));
		group_done = col_cur[2:0] == 3'd7;
	end

	// handshake: the stage stalls only on a full group with no room in the queue
	always_comb begin
		stall  = group_done && q_full;
		fire   = valid_s1 && !stall;
		full   = valid_s1 && stall;
		accept = push && !full;
		q_wr   = fire && group_done;
	end

	// group descriptor
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			q_wr_data.values[k] = (k == 7) ? grey : grp_q[k];
		end
		q_wr_data.start_addr = base_cur + ADDR_W'(col_cur >> 3);
		q_wr_data.frame_done = last_row && last_col;
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel_rgb565;
			fs_s1  <= frame_start;
		end
	end

	// row and column counters, group store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			base_q <= '0;
			for (int k = 0; k < 8; k++) begin
				grp_q[k] <= '0;
			end
		end else if (fire) begin
			grp_q[col_cur[2:0]] <= grey;
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					base_q <= '0;
				end else begin
					row_q  <= row_inc[RW-1:0];
					base_q <= base_cur + row_stride;
				end
			end else begin
				col_q  <= col_inc[CW-1:0];
				row_q  <= row_cur;
				base_q <= base_cur;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(pix_s1) && $stable(fs_s1))
		else $error("front stage lost a stalled pixel");
`endif

endmodule

FILE: sv/rgbbp_queue.sv
module rgbbp_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  rgbbp_pkg::desc_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output rgbbp_pkg::desc_t rd_data,
	output logic             empty
);
	import rgbbp_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	desc_t           mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	// status
	always_comb begin
		full    = count_q == CNTW'(DEPTH);
		empty   = count_q == '0;
		do_wr   = wr_en && !full;
		do_rd   = rd_en && !empty;
		rd_data = mem_q[rd_ptr_q];
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("group queue count out of range");
`endif

endmodule

FILE: sv/rgbbp_back.sv
module rgbbp_back #(
	parameter int MAX_PLANES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rgbbp_pkg::cfg_t  cfg,
	input  logic             q_empty,
	output logic             q_rd,
	input  rgbbp_pkg::desc_t q_rd_data,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       plane_byte,
	output logic [19:0]      byte_address,
	output logic             last_of_group,
	output logic             end_of_frame
);
	import rgbbp_pkg::*;

	localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

	logic              busy_q;
	logic [PW-1:0]     plane_q;
	logic [ADDR_W-1:0] addr_q;
	desc_t             cur_q;

	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic              last_q;
	logic              eof_q;

	logic              can_emit;
	logic              emit;
	logic              is_last;
	logic [7:0]        byte_nx;

	// sequencing over planes
	always_comb begin
		can_emit = !out_valid_q || pop;
		emit     = busy_q && can_emit;
		is_last  = plane_q == PW'(cfg.plane_count - 4'd1);
		q_rd     = !q_empty && (!busy_q || (emit && is_last));
	end

	// gather bit p of the eight pixels, leftmost pixel in the top bit
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			byte_nx[7-k] = cur_q.values[k][plane_q];
		end
	end

	// plane sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			plane_q <= '0;
		end else if (q_rd) begin
			busy_q  <= 1'b1;
			plane_q <= '0;
		end else if (emit) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				plane_q <= plane_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q  <= q_rd_data;
			addr_q <= q_rd_data.start_addr;
		end else if (emit) begin
			addr_q <= addr_q + ADDR_W'(cfg.row_bytes);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q     <= byte_nx;
			out_addr_q <= addr_q;
			last_q     <= is_last;
			eof_q      <= is_last && cur_q.frame_done;
		end
	end

	assign empty         = !out_valid_q;
	assign plane_byte    = byte_q;
	assign byte_address  = out_addr_q;
	assign last_of_group = last_q;
	assign end_of_frame  = eof_q;

`ifndef NO_ASSERTIONS
	a_plane_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> 4'(plane_q) < cfg.plane_count)
		else $error("plane index beyond plane count");
	a_eof_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && eof_q |-> last_q)
		else $error("end of frame flagged on a byte that does not close its group");
`endif

endmodule

FILE: sv/rgb565_grey_to_bitplanes.sv
// Chunky-to-planar converter: takes one RGB565 pixel per clock, turns it into a
// grey value (q16 luma weights, then a configurable right shift) and, for every
// eight pixels of a row, writes one byte per bitplane with its offset in
// row-interleaved planar memory. The front end accepts a pixel every cycle
// unless stalled and puts a finished group into a two-deep queue once its
// eighth pixel has left the input stage register and the queue has room; with
// the back end idle, its first plane byte then passes the back end's group and
// output registers. The back end emits one plane byte per cycle through an
// output register while pop is high. As a group has no more planes than pixels,
// the block then sustains one pixel per clock for any plane count up to eight;
// a pixel that completes a group stalls the input only while the queue is full.
// Configuration is clamped when written (zero counts read as one, large ones
// saturate) and must be changed only while the block is idle.
module rgb565_grey_to_bitplanes #(
	parameter int MAX_ROW_BYTES = 128,
	parameter int MAX_ROWS      = 1024,
	parameter int MAX_PLANES    = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rgbbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rgbbp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic [15:0]                         pixel_rgb565,
	input  logic                                frame_start,
	output logic                                empty,
	input  logic                                pop,
	output logic [7:0]                          plane_byte,
	output logic [19:0]                         byte_address,
	output logic                                last_of_group,
	output logic                                end_of_frame
);
	import rgbbp_pkg::*;

	localparam int QUEUE_DEPTH = 2;

	localparam int RB_MAX_I   = (MAX_ROW_BYTES > ROW_BYTES_FIELD_MAX) ?
		ROW_BYTES_FIELD_MAX : MAX_ROW_BYTES;
	localparam int ROWS_MAX_I = (MAX_ROWS > ROW_COUNT_FIELD_MAX) ?
		ROW_COUNT_FIELD_MAX : MAX_ROWS;

	localparam logic [3:0]  PL_MAX   = 4'(MAX_PLANES);
	localparam logic [7:0]  RB_MAX   = 8'(RB_MAX_I);
	localparam logic [10:0] ROWS_MAX = 11'(ROWS_MAX_I);

	localparam logic [3:0]  PL_RST   = 4'((PLANE_COUNT_RST > MAX_PLANES) ?
		MAX_PLANES : PLANE_COUNT_RST);
	localparam logic [7:0]  RB_RST   = 8'((ROW_BYTES_RST > RB_MAX_I) ?
		RB_MAX_I : ROW_BYTES_RST);
	localparam logic [10:0] ROWS_RST = 11'((ROW_COUNT_RST > ROWS_MAX_I) ?
		ROWS_MAX_I : ROW_COUNT_RST);

	cfg_t        cfg_q;
	logic        cfg_wr;
	logic [3:0]  pc_in;
	logic [7:0]  rb_in;
	logic [10:0] rows_in;
	logic [3:0]  pc_clamped;
	logic [7:0]  rb_clamped;
	logic [10:0] rows_clamped;

	logic        q_wr;
	desc_t       q_wr_data;
	logic        q_full;
	logic        q_rd;
	desc_t       q_rd_data;
	logic        q_empty;

	// clamp register values as they are written
	always_comb begin
		cfg_ready    = 1'b1;
		cfg_wr       = cfg_valid && cfg_ready;
		pc_in        = cfg_data[3:0];
		rb_in        = cfg_data[7:0];
		rows_in      = cfg_data[10:0];
		pc_clamped   = (pc_in == '0) ? 4'd1 :
			((int'(pc_in) > MAX_PLANES) ? PL_MAX : pc_in);
		rb_clamped   = (rb_in == '0) ? 8'd1 :
			((int'(rb_in) > RB_MAX_I) ? RB_MAX : rb_in);
		rows_clamped = (rows_in == '0) ? 11'd1 :
			((int'(rows_in) > ROWS_MAX_I) ? ROWS_MAX : rows_in);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grey_shift  <= 3'(GREY_SHIFT_RST);
			cfg_q.plane_count <= PL_RST;
			cfg_q.row_bytes   <= RB_RST;
			cfg_q.row_count   <= ROWS_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_GREY_SHIFT:  cfg_q.grey_shift  <= cfg_data[2:0];
				REG_PLANE_COUNT: cfg_q.plane_count <= pc_clamped;
				REG_ROW_BYTES:   cfg_q.row_bytes   <= rb_clamped;
				REG_ROW_COUNT:   cfg_q.row_count   <= rows_clamped;
				default: begin
				end
			endcase
		end
	end

	rgbbp_front #(
		.MAX_ROW_BYTES (MAX_ROW_BYTES),
		.MAX_ROWS      (MAX_ROWS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.pixel_rgb565 (pixel_rgb565),
		.frame_start  (frame_start),
		.q_wr         (q_wr),
		.q_wr_data    (q_wr_data),
		.q_full       (q_full)
	);

	rgbbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	rgbbp_back #(
		.MAX_PLANES (MAX_PLANES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_rd          (q_rd),
		.q_rd_data     (q_rd_data),
		.empty         (empty),
		.pop           (pop),
		.plane_byte    (plane_byte),
		.byte_address  (byte_address),
		.last_of_group (last_of_group),
		.end_of_frame  (end_of_frame)
	);

endmodule

FILE: test/tb_rgb565_grey_to_bitplanes.sv
`timescale 1ns / 1ps

module tb_rgb565_grey_to_bitplanes;
	import rgbbp_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 16;
	localparam int NUM_SEGS      = 9;
	localparam int SEG_ITEMS     = 34;

	// limits the block is built with
	localparam int unsigned ROW_BYTES_LIMIT = 128;
	localparam int unsigned ROWS_LIMIT      = 1024;
	localparam int unsigned PLANES_LIMIT    = 8;

	// q16 luma weights
	localparam int unsigned LUMA_R = 19661;
	localparam int unsigned LUMA_G = 38011;
	localparam int unsigned LUMA_B = 7209;

	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 4'd4;
	localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 4'd15;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  push;
	logic                  full;
	logic [15:0]           pixel_rgb565;
	logic                  frame_start;
	logic                  empty;
	logic                  pop;
	logic [7:0]            plane_byte;
	logic [19:0]           byte_address;
	logic                  last_of_group;
	logic                  end_of_frame;

	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_req;
	int cycle_count;

	typedef struct {
		logic [7:0]  pbyte;
		logic [19:0] addr;
		logic        last;
		logic        eof;
	} plane_beat_t;

	// predicts the plane bytes of the pixel stream and checks them in order
	class plane_scoreboard;
		logic [2:0]  grey_shift;
		logic [3:0]  plane_count;
		logic [7:0]  row_bytes;
		logic [10:0] row_count;
		logic [7:0]  group_vals [8];
		int unsigned col;
		int unsigned row;
		logic [19:0] row_base;
		plane_beat_t expected_q [$];
		int          mismatches;
		int          beats_checked;
		int          frames_seen;
		int          pixels_noted;

		function new();
			grey_shift  = 3'(GREY_SHIFT_RST);
			plane_count = 4'(PLANE_COUNT_RST);
			row_bytes   = 8'(ROW_BYTES_RST);
			row_count   = 11'(ROW_COUNT_RST);
			foreach (group_vals[k])
				group_vals[k] = '0;
			col           = 0;
			row           = 0;
			row_base      = '0;
			mismatches    = 0;
			beats_checked = 0;
			frames_seen   = 0;
			pixels_noted  = 0;
		endfunction

		function int unsigned clamp_size(int unsigned v, int unsigned hi);
			if (v == 0)
				return 1;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GREY_SHIFT:  grey_shift  = data[2:0];
				REG_PLANE_COUNT: plane_count = data[3:0];
				REG_ROW_BYTES:   row_bytes   = data[7:0];
				REG_ROW_COUNT:   row_count   = data[10:0];
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [15:0] pix, logic fs);
			int unsigned planes;
			int unsigned rb;
			int unsigned rows;
			int unsigned col_limit;
			int unsigned luma;
			logic [7:0]  grey;
			logic        frame_done;
			plane_beat_t b;
			planes    = clamp_size(plane_count, PLANES_LIMIT);
			rb        = clamp_size(row_bytes, ROW_BYTES_LIMIT);
			rows      = clamp_size(row_count, ROWS_LIMIT);
			col_limit = rb * 8;
			pixels_noted++;

			if (fs) begin
				col      = 0;
				row      = 0;
				row_base = '0;
			end

			// grey value of this pixel into its slot of the group
			luma = (32'(pix[15:11]) * LUMA_R + 32'(pix[10:5]) * LUMA_G
				+ 32'(pix[4:0]) * LUMA_B) >> 16;
			grey = 8'(luma);
			group_vals[col % 8] = grey >> grey_shift;

			// eighth pixel of a group: one byte per plane
			if (col % 8 == 7) begin
				frame_done = (row + 1 >= rows) && (col + 1 >= col_limit);
				for (int p = 0; p < int'(planes); p++) begin
					b.pbyte = '0;
					for (int k = 0; k < 8; k++)
						if (group_vals[k][p])
							b.pbyte[7-k] = 1'b1;
					b.addr = 20'(32'(row_base) + p * rb + col / 8);
					b.last = (p + 1 == int'(planes));
					b.eof  = b.last && frame_done;
					expected_q.push_back(b);
				end
			end

			// advance column, row and row base
			col++;
			if (col >= col_limit) begin
				col      = 0;
				row++;
				row_base = 20'(32'(row_base) + rb * planes);
				if (row >= rows) begin
					row      = 0;
					row_base = '0;
				end
			end
		endfunction

		function void check_beat(plane_beat_t got);
			plane_beat_t want;
			beats_checked++;
			if (got.eof)
				frames_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: byte %02h addr %05h last %0b eof %0b",
						got.pbyte, got.addr, got.last, got.eof);
				return;
			end
			want = expected_q.pop_front();
			if (got.pbyte !== want.pbyte || got.addr !== want.addr
				|| got.last !== want.last || got.eof !== want.eof) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: byte %02h/%02h addr %05h/%05h last %0b/%0b eof %0b/%0b (exp/act)",
						want.pbyte, got.pbyte, want.addr, got.addr,
						want.last, got.last, want.eof, got.eof);
			end
		endfunction
	endclass

	plane_scoreboard sb = new();

	rgb565_grey_to_bitplanes uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.pixel_rgb565  (pixel_rgb565),
		.frame_start   (frame_start),
		.empty         (empty),
		.pop           (pop),
		.plane_byte    (plane_byte),
		.byte_address  (byte_address),
		.last_of_group (last_of_group),
		.end_of_frame  (end_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one pixel beat, with random gaps before it
	task automatic send_pixel(input logic [15:0] pix, input logic fs);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		pixel_rgb565 <= pix;
		frame_start  <= fs;
		do @(posedge clk); while (full);
		sb.note_pixel(pix, fs);
	endtask

	// stop sending and wait until every predicted byte is out
	task automatic drain_results();
		push <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves valid high so that writes can follow back to back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, CFG_DATA_W'(value));
	endtask

	// negative value leaves that register alone
	task automatic reconfigure(input int shift, input int planes, input int rbytes, input int rows);
		if (shift >= 0)
			write_reg(REG_GREY_SHIFT, shift);
		if (planes >= 0)
			write_reg(REG_PLANE_COUNT, planes);
		if (rbytes >= 0)
			write_reg(REG_ROW_BYTES, rbytes);
		if (rows >= 0)
			write_reg(REG_ROW_COUNT, rows);
		cfg_valid <= 1'b0;
	endtask

	// mostly small sizes, sometimes zero or the field maximum
	function automatic int pick_size(int common_hi, int field_max);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return field_max;
			2: return $urandom_range(0, field_max);
			default: return $urandom_range(1, common_hi);
		endcase
	endfunction

	// result side: check each beat, random stalls, long hold on request
	initial begin : result_side
		plane_beat_t got;
		int          hold_left;
		hold_left = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.pbyte = plane_byte;
				got.addr  = byte_address;
				got.last  = last_of_group;
				got.eof   = end_of_frame;
				sb.check_beat(got);
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d bytes still expected",
			cycle_count, sb.expected_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [15:0] corner_pix [8];
		logic [15:0] pix;
		logic        fs;
		corner_pix = '{16'hFFFF, 16'h0000, 16'hF800, 16'h07E0,
			16'h001F, 16'h8410, 16'h7BEF, 16'hAAAA};
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req    = 1'b0;
		arst_n       = 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		push         <= 1'b0;
		pixel_rgb565 <= '0;
		frame_start  <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// color extremes under the reset configuration
		tx_idle_pct = 33;
		rx_idle_pct = 67;
		foreach (corner_pix[i])
			send_pixel(corner_pix[i], i == 0);

		// unused indexes, then one-byte rows in a one-row frame, all planes
		drain_results();
		write_reg(IDX_UNUSED_LO, 11'h2AA);
		write_reg(IDX_UNUSED_HI, 11'h7FF);
		reconfigure(0, 8, 1, 1);
		for (int i = 7; i >= 0; i--)
			send_pixel(corner_pix[i], 1'b0);

		// zero counts read as one; frame start in the middle of a group
		drain_results();
		reconfigure(7, 0, 0, 0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'hF81F, 1'b0);
		send_pixel(16'h07FF, 1'b1);
		for (int i = 0; i < 7; i++)
			send_pixel(corner_pix[i], 1'b0);

		// oversized values saturate
		drain_results();
		reconfigure(3, 15, 255, 2047);

		// random segments: sender 33 / receiver 67, then swapped, then no idling
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			if (seg < 3) begin
				tx_idle_pct = 33;
				rx_idle_pct = 67;
			end else if (seg < 6) begin
				tx_idle_pct = 67;
				rx_idle_pct = 33;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (seg > 0) begin
				drain_results();
				reconfigure(($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 7)) : -1,
					($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 15)) : -1,
					($urandom_range(0, 3) != 0) ? pick_size(4, ROW_BYTES_FIELD_MAX) : -1,
					($urandom_range(0, 3) != 0) ? pick_size(3, ROW_COUNT_FIELD_MAX) : -1);
			end
			// receiver stalls long while pixels keep coming
			if (seg == 1 || seg == 7)
				hold_req = 1'b1;
			for (int i = 0; i < SEG_ITEMS; i++) begin
				if ($urandom_range(0, 7) == 0)
					pix = corner_pix[$urandom_range(0, 7)];
				else
					pix = 16'($urandom_range(0, 65535));
				fs = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
				send_pixel(pix, fs);
			end
		end

		drain_results();
		$display("run covered %0d pixels and %0d plane bytes over %0d finished frames",
			sb.pixels_noted, sb.beats_checked, sb.frames_seen);
		$display("configuration changed between segments, %0d mismatches in %0d cycles",
			sb.mismatches, cycle_count);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
